>>> hdl/hoe_pkg.sv
// Shared types, codes and constants for the header object extractor.
// No dependencies; every other file of the block depends on it.
`default_nettype none

package hoe_pkg;

  // Upper bound on the object size limit; the register value is capped at this.
  localparam int LENGTH_LIMIT_MAX = 65536;

  localparam int LEN_W = 17;
  localparam int KEY_LEN = 6;

  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic [2:0] {
    ST_SCAN         = 3'd0,
    ST_DONE         = 3'd1,
    ST_NO_OPEN      = 3'd2,
    ST_UNQUOTED     = 3'd3,
    ST_KEY_MISMATCH = 3'd4,
    ST_NOT_OBJECT   = 3'd5,
    ST_EARLY_END    = 3'd6,
    ST_TOO_LONG     = 3'd7
  } status_t;

  typedef enum logic [6:0] {
    PH_OPEN  = 7'b0000001,
    PH_QUOTE = 7'b0000010,
    PH_KEY   = 7'b0000100,
    PH_COLON = 7'b0001000,
    PH_VALUE = 7'b0010000,
    PH_BODY  = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{8'h48, 8'h65, 8'h61, 8'h64, 8'h65, 8'h72};

  // One input beat as held in the input register.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       stream_end;
  } item_t;

endpackage

`default_nettype wire

>>> hdl/hoe_ifs.sv
// Valid/ready channel interfaces for the input byte stream and the result stream.
// Depends on hoe_pkg for the length type.
`default_nettype none

interface hoe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       stream_end;

  modport source (output valid, output text_byte, output stream_end, input ready);
  modport sink (input valid, input text_byte, input stream_end, output ready);
endinterface

interface hoe_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic              object_valid;
  logic [7:0]        object_byte;
  logic              object_last;
  hoe_pkg::len_t     object_length;

  modport source (output valid, output status, output object_valid, output object_byte,
                  output object_last, output object_length, input ready);
  modport sink (input valid, input status, input object_valid, input object_byte,
                input object_last, input object_length, output ready);
endinterface

`default_nettype wire

>>> hdl/hoe_in_stage.sv
// Input register: captures one beat from the byte channel and holds it until the scanner takes it.
// Depends on hoe_pkg and hoe_in_if.
`default_nettype none

module hoe_in_stage (
  input  wire            clk,
  input  wire            rst_n,
  hoe_in_if.sink         in_bus,
  input  wire            take,
  output logic           item_valid,
  output hoe_pkg::item_t item
);
  import hoe_pkg::*;

  logic  valid_r;
  item_t item_r;

  // Refill in the same cycle the held beat moves on.
  assign in_bus.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      item_r.text_byte  <= in_bus.text_byte;
      item_r.stream_end <= in_bus.stream_end;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> hdl/hoe_scanner.sv
// Scanner: parse state, per-beat update logic and the result register.
// Depends on hoe_pkg and hoe_out_if.
`default_nettype none

module hoe_scanner (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            item_valid,
  input  hoe_pkg::item_t item,
  input  hoe_pkg::len_t  limit,
  output logic           take,
  hoe_out_if.source      out_bus
);
  import hoe_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [2:0] kpos_r, kpos_nxt;
  logic       kmis_r, kmis_nxt;
  len_t       depth_r, depth_nxt;
  logic       in_str_r, in_str_nxt;
  logic       esc_r, esc_nxt;
  len_t       count_r, count_nxt;
  status_t    fstat_r, fstat_nxt;

  logic       out_valid_r;
  status_t    status_r;
  logic       obj_valid_r, obj_valid_nxt;
  logic [7:0] obj_byte_r;
  logic       obj_last_r, obj_last_nxt;
  len_t       obj_len_r;

  logic [7:0] b;
  logic       ends;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  assign take = item_valid && (!out_valid_r || out_bus.ready);
  assign b    = item.text_byte;
  assign ends = item.stream_end;

  always_comb begin
    phase_nxt     = phase_r;
    kpos_nxt      = kpos_r;
    kmis_nxt      = kmis_r;
    depth_nxt     = depth_r;
    in_str_nxt    = in_str_r;
    esc_nxt       = esc_r;
    count_nxt     = count_r;
    fstat_nxt     = fstat_r;
    obj_valid_nxt = 1'b0;
    obj_last_nxt  = 1'b0;
    case (phase_r)
      PH_OPEN: begin
        if (ends || (!is_space(b) && b != CH_LBRACE)) begin
          fstat_nxt = ST_NO_OPEN;
          phase_nxt = PH_DONE;
        end else if (b == CH_LBRACE) begin
          phase_nxt = PH_QUOTE;
        end
      end
      PH_QUOTE: begin
        if (ends || (!is_space(b) && b != CH_QUOTE)) begin
          fstat_nxt = ST_UNQUOTED;
          phase_nxt = PH_DONE;
        end else if (b == CH_QUOTE) begin
          phase_nxt = PH_KEY;
          kpos_nxt  = 3'd0;
          kmis_nxt  = 1'b0;
        end
      end
      PH_KEY: begin
        if (ends || b == CH_QUOTE) begin
          if (kmis_r || kpos_r != 3'(KEY_LEN)) begin
            fstat_nxt = ST_KEY_MISMATCH;
            phase_nxt = PH_DONE;
          end else if (ends) begin
            fstat_nxt = ST_NOT_OBJECT;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_COLON;
          end
        end else if (kpos_r >= 3'(KEY_LEN)) begin
          kmis_nxt = 1'b1;
        end else begin
          if (KEY_TEXT[kpos_r] != b) begin
            kmis_nxt = 1'b1;
          end
          kpos_nxt = kpos_r + 3'd1;
        end
      end
      PH_COLON: begin
        if (ends || (!is_space(b) && b != CH_COLON)) begin
          fstat_nxt = ST_NOT_OBJECT;
          phase_nxt = PH_DONE;
        end else if (b == CH_COLON) begin
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (ends || (!is_space(b) && b != CH_LBRACE)) begin
          fstat_nxt = ST_NOT_OBJECT;
          phase_nxt = PH_DONE;
        end else if (b == CH_LBRACE) begin
          phase_nxt     = PH_BODY;
          depth_nxt     = len_t'(1);
          in_str_nxt    = 1'b0;
          esc_nxt       = 1'b0;
          count_nxt     = len_t'(1);
          obj_valid_nxt = 1'b1;
        end
      end
      PH_BODY: begin
        if (ends) begin
          fstat_nxt = ST_EARLY_END;
          phase_nxt = PH_DONE;
        end else if (count_r >= limit) begin
          fstat_nxt = ST_TOO_LONG;
          phase_nxt = PH_DONE;
        end else begin
          count_nxt     = count_r + len_t'(1);
          obj_valid_nxt = 1'b1;
          if (in_str_r) begin
            if (esc_r) begin
              esc_nxt = 1'b0;
            end else if (b == CH_BSLASH) begin
              esc_nxt = 1'b1;
            end else if (b == CH_QUOTE) begin
              in_str_nxt = 1'b0;
            end
          end else if (b == CH_QUOTE) begin
            in_str_nxt = 1'b1;
          end else if (b == CH_LBRACE) begin
            depth_nxt = depth_r + len_t'(1);
          end else if (b == CH_RBRACE) begin
            // Depth is at least one here, so the balancing brace takes it to zero.
            depth_nxt = depth_r - len_t'(1);
            if (depth_r == len_t'(1)) begin
              obj_last_nxt = 1'b1;
              fstat_nxt    = ST_DONE;
              phase_nxt    = PH_DONE;
            end
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPEN;
      kpos_r      <= 3'd0;
      kmis_r      <= 1'b0;
      depth_r     <= '0;
      in_str_r    <= 1'b0;
      esc_r       <= 1'b0;
      count_r     <= '0;
      fstat_r     <= ST_SCAN;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r  <= phase_nxt;
        kpos_r   <= kpos_nxt;
        kmis_r   <= kmis_nxt;
        depth_r  <= depth_nxt;
        in_str_r <= in_str_nxt;
        esc_r    <= esc_nxt;
        count_r  <= count_nxt;
        fstat_r  <= fstat_nxt;
      end
      if (!out_valid_r || out_bus.ready) begin
        out_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status_r    <= fstat_nxt;
      obj_valid_r <= obj_valid_nxt;
      obj_byte_r  <= obj_valid_nxt ? b : 8'd0;
      obj_last_r  <= obj_last_nxt;
      obj_len_r   <= count_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.status        = status_r;
  assign out_bus.object_valid  = obj_valid_r;
  assign out_bus.object_byte   = obj_byte_r;
  assign out_bus.object_last   = obj_last_r;
  assign out_bus.object_length = obj_len_r;

  a_last_completes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && obj_last_r |-> status_r == ST_DONE && obj_valid_r)
    else $error("closing beat without completion status");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("left the finished phase without reset");

  a_body_depth: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> depth_r != '0 && count_r != '0)
    else $error("object body with zero depth or count");

  a_copy_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && obj_valid_r |-> status_r == ST_SCAN || status_r == ST_DONE)
    else $error("object byte copied alongside an error status");

endmodule

`default_nettype wire

>>> hdl/header_object_extractor.sv
// Header object extractor: one text byte per beat in, one result per beat out. The block
// accepts a byte every clock cycle while the result channel is ready; each result passes
// through the input register and then the result register, with the whole parse update
// between them. Back-pressure on the result channel stalls the input after one
// buffered beat. The size limit register may only be written while the block is idle.
//
// Top level; depends on hoe_pkg, hoe_ifs, hoe_in_stage and hoe_scanner.
`default_nettype none

module header_object_extractor (
  input  wire                 clk,
  input  wire                 rst_n,
  hoe_in_if.sink              in_bus,
  hoe_out_if.source           out_bus,
  input  wire                 cfg_wr_en,
  input  wire [hoe_pkg::LEN_W-1:0] cfg_wr_data
);
  import hoe_pkg::*;

  localparam logic [20:0] LIMIT_CAP = 21'(LENGTH_LIMIT_MAX);

  len_t  max_bytes_r;
  len_t  limit;
  logic  item_valid;
  item_t item;
  logic  take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= LIMIT_CAP[LEN_W-1:0];
    end else if (cfg_wr_en) begin
      max_bytes_r <= cfg_wr_data;
    end
  end

  // Use the smaller of the register and the build-time cap.
  assign limit = ({4'd0, max_bytes_r} < LIMIT_CAP) ? max_bytes_r : LIMIT_CAP[LEN_W-1:0];

  hoe_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  hoe_scanner u_scanner (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .limit      (limit),
    .take       (take),
    .out_bus    (out_bus)
  );

endmodule

`default_nettype wire
